// ===== src/grwhf_pkg.sv =====
// Shared types and constants for the grid ray wall hit fraction block.
// Used by every module in src; no dependencies of its own.
package grwhf_pkg;

  localparam int COORD_W    = 24;  // signed world coordinate
  localparam int DELTA_W    = 25;  // segment delta and cell position
  localparam int CELL_W     = 20;  // cell size register
  localparam int NSTEP_W    = 26;  // distance to the next crossing
  localparam int DIVN_W     = 41;  // divider dividend
  localparam int DIVD_W     = 25;  // divider divisor
  localparam int CNT_W      = 6;
  localparam int PROD_W     = NSTEP_W + DIVD_W;
  localparam int EDGE_W     = 29;  // (position + 1) * cell size inside the grid
  localparam int NUM_W      = 31;
  localparam int MAP_DEPTH  = 2048;
  localparam int MAP_AW     = 11;
  localparam int GRID_POS_BITS = 8;
  localparam int GRID_IDX_W = 17;
  localparam int FRAC_W     = 17;
  localparam int FRAC_BITS  = 16;
  localparam int COL_W      = 6;
  localparam int ROW_W      = 5;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
  localparam logic [CELL_W-1:0] CELL_SIZE_RESET = 20'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quotient;
    logic [DIVD_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== src/grwhf_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on grwhf_pkg for widths and the request/response structs.
module grwhf_div (
  input  logic                clk,
  input  logic                rst_n,
  input  grwhf_pkg::div_req_t req,
  output grwhf_pkg::div_rsp_t rsp
);

  logic [grwhf_pkg::DIVD_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [grwhf_pkg::DIVN_W-1:0] quo_r;
  logic [grwhf_pkg::CNT_W-1:0]  cnt_r;
  logic                         busy_r, done_r;
  logic [grwhf_pkg::DIVD_W:0]   trial, diff;
  logic                         ge;

  always_comb begin
    trial   = {rem_r, quo_r[grwhf_pkg::DIVN_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[grwhf_pkg::DIVD_W-1:0] : trial[grwhf_pkg::DIVD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      cnt_r <= grwhf_pkg::CNT_W'(grwhf_pkg::DIVN_W - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[grwhf_pkg::DIVN_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== src/grwhf_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on grwhf_pkg for operand widths.
module grwhf_mul (
  input  logic                          clk,
  input  logic [grwhf_pkg::NSTEP_W-1:0] a,
  input  logic [grwhf_pkg::DIVD_W-1:0]  b,
  output logic [grwhf_pkg::PROD_W-1:0]  p
);

  logic [grwhf_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= grwhf_pkg::PROD_W'(a) * grwhf_pkg::PROD_W'(b);
  end

  assign p = p_r;

endmodule

// ===== src/grwhf_wall_map.sv =====
// One-bit wall map memory with a clearing pass after reset.
// Depends on grwhf_pkg for depth and address width.
module grwhf_wall_map (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [grwhf_pkg::MAP_AW-1:0] wr_addr,
  input  logic                         wr_bit,
  input  logic [grwhf_pkg::MAP_AW-1:0] rd_addr,
  output logic                         rd_bit,
  output logic                         ready
);

  logic                         mem [grwhf_pkg::MAP_DEPTH];
  logic [grwhf_pkg::MAP_AW-1:0] clr_cnt_r;
  logic                         clr_busy_r;
  logic                         rd_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    rd_bit_r <= mem[rd_addr];
  end

  assign rd_bit = rd_bit_r;
  assign ready  = !clr_busy_r;

endmodule

// ===== src/grid_ray_wall_hit_fraction.sv =====
// Top level of the grid ray wall hit fraction block: sequencer and datapath.
// Depends on grwhf_pkg, grwhf_div, grwhf_mul and grwhf_wall_map.
//
// Usage: the input stream carries write and query transactions, selected by
// in_tuser (0 write one wall map cell, 1 segment query). Every input
// transaction yields exactly one output transaction on the out_ stream.
// A query first runs four floor divisions on the shared divider (cell of
// the start and end points), each with its start and done handshake, then
// walks the grid: each cell step takes two products on the shared
// multiplier (when both deltas are nonzero), the step and, for a cell inside
// the grid, the map lookup with its registered read. A wall hit adds the
// edge product and, for a fraction strictly between zero and one, one more
// division; a start far outside the grid walks every cell back toward it.
// One item is in work at a time; in_tready is low meanwhile.
// The result sits in an output register, so the next item can be taken
// while out_tvalid waits on a stalled receiver; a further finished result
// then waits inside until the register frees.
// After reset the wall map is cleared one cell a cycle; until every cell is
// clear in_tready stays low, while configuration writes are still taken.
// cfg_index 0 sets the cell width, 1 the cell height (Q8.12, zero acts as the least step, 1/4096).
module grid_ray_wall_hit_fraction #(
  parameter int GRID_COLUMNS = 64,
  parameter int GRID_ROWS    = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // cell_index[10:0], cell_wall[11], from_x[35:12], from_y[59:36],
  // to_x[83:60], to_y[107:84], zero pad above
  input  logic [grwhf_pkg::IN_DATA_W-1:0]       in_tdata,
  // command[0]
  input  logic [0:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // hit[0], fraction[17:1], hit_column[23:18], hit_row[28:24], zero pad above
  output logic [grwhf_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [grwhf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [grwhf_pkg::CELL_W-1:0]          cfg_data
);

  localparam int PW = grwhf_pkg::DELTA_W;
  localparam logic signed [PW-1:0] COLS_S = PW'(GRID_COLUMNS);
  localparam logic signed [PW-1:0] ROWS_S = PW'(GRID_ROWS);

  typedef enum logic [3:0] {
    S_IDLE, S_DSTART, S_DWAIT, S_CHECK, S_MUL1, S_MUL2, S_STEP,
    S_TEST, S_READ, S_EDGE, S_FDIV, S_DONE
  } state_t;

  state_t state_r;

  logic [grwhf_pkg::CELL_W-1:0] cell_width_r, cell_height_r, w_eff, h_eff;

  logic signed [grwhf_pkg::COORD_W-1:0] fx_r, fy_r, tx_r, ty_r;
  logic signed [PW-1:0] dx_r, dy_r, x_r, y_r, ex_r, ey_r;
  logic [PW-1:0] adx_r, ady_r;
  logic [grwhf_pkg::NSTEP_W-1:0] nx_r, ny_r;
  logic dxpos_r, dypos_r, dxz_r, dyz_r, stepx_r;
  logic [1:0] sel_r;
  logic [grwhf_pkg::PROD_W-1:0] prod_a_r;

  logic res_hit_r;
  logic [grwhf_pkg::FRAC_W-1:0] res_frac_r;
  logic [grwhf_pkg::COL_W-1:0] res_col_r;
  logic [grwhf_pkg::ROW_W-1:0] res_row_r;
  logic out_valid_r;
  logic [grwhf_pkg::OUT_DATA_W-1:0] out_data_r;

  // Input fields
  logic [grwhf_pkg::MAP_AW-1:0] in_cell_index;
  logic in_cell_wall, in_command, in_accept;
  logic signed [grwhf_pkg::COORD_W-1:0] in_from_x, in_from_y, in_to_x, in_to_y;
  logic signed [PW-1:0] in_dx, in_dy;

  assign in_cell_index = in_tdata[10:0];
  assign in_cell_wall  = in_tdata[11];
  assign in_from_x     = in_tdata[35:12];
  assign in_from_y     = in_tdata[59:36];
  assign in_to_x       = in_tdata[83:60];
  assign in_to_y       = in_tdata[107:84];
  assign in_command    = in_tuser[0];
  assign in_dx         = PW'(in_to_x) - PW'(in_from_x);
  assign in_dy         = PW'(in_to_y) - PW'(in_from_y);

  // Units
  grwhf_pkg::div_req_t div_req;
  grwhf_pkg::div_rsp_t div_rsp;
  logic [grwhf_pkg::NSTEP_W-1:0] mul_a;
  logic [grwhf_pkg::DIVD_W-1:0]  mul_b;
  logic [grwhf_pkg::PROD_W-1:0]  mul_p;
  logic map_ready, map_rd_bit, map_wr_en;
  logic [grwhf_pkg::MAP_AW-1:0] map_rd_addr;

  grwhf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  grwhf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  grwhf_wall_map u_map (
    .clk(clk), .rst_n(rst_n), .wr_en(map_wr_en), .wr_addr(in_cell_index),
    .wr_bit(in_cell_wall), .rd_addr(map_rd_addr), .rd_bit(map_rd_bit),
    .ready(map_ready)
  );

  assign in_tready = (state_r == S_IDLE) && map_ready;
  assign in_accept = in_tvalid && in_tready;
  assign map_wr_en = in_accept && (in_command == grwhf_pkg::CMD_WRITE);

  assign w_eff = (cell_width_r  == '0) ? grwhf_pkg::CELL_W'(1) : cell_width_r;
  assign h_eff = (cell_height_r == '0) ? grwhf_pkg::CELL_W'(1) : cell_height_r;

  // Floor division operand selected by the setup phase
  logic signed [grwhf_pkg::COORD_W-1:0] fd_a;
  logic [grwhf_pkg::COORD_W-1:0] fd_mag;
  logic [grwhf_pkg::CELL_W-1:0] fd_w, fd_r, fd_rf;
  logic [PW-1:0] fd_q;
  logic signed [PW-1:0] fd_pos;
  logic fd_neg, fd_rnz, fd_dpos;
  logic [grwhf_pkg::NSTEP_W-1:0] fd_n;

  always_comb begin
    case (sel_r)
      2'd0:    fd_a = fx_r;
      2'd1:    fd_a = fy_r;
      2'd2:    fd_a = tx_r;
      default: fd_a = ty_r;
    endcase
    fd_w    = sel_r[0] ? h_eff : w_eff;
    fd_dpos = sel_r[0] ? dypos_r : dxpos_r;
    fd_neg  = fd_a[grwhf_pkg::COORD_W-1];
    fd_mag  = fd_neg ? -fd_a : fd_a;
    fd_q    = {1'b0, div_rsp.quotient[grwhf_pkg::COORD_W-1:0]};
    fd_r    = div_rsp.remainder[grwhf_pkg::CELL_W-1:0];
    fd_rnz  = fd_r != '0;
    if (!fd_neg) begin
      fd_pos = $signed(fd_q);
      fd_rf  = fd_r;
    end else if (fd_rnz) begin
      fd_pos = -$signed(fd_q + 1'b1);
      fd_rf  = fd_w - fd_r;
    end else begin
      fd_pos = -$signed(fd_q);
      fd_rf  = '0;
    end
    fd_n = fd_dpos ? grwhf_pkg::NSTEP_W'(fd_w - fd_rf) : grwhf_pkg::NSTEP_W'(fd_rf);
  end

  // Walk control
  logic rx, ry, brk, in_grid;
  logic [grwhf_pkg::GRID_IDX_W-1:0] cell_idx;

  always_comb begin
    rx  = dxpos_r ? (x_r >= ex_r) : (x_r <= ex_r);
    ry  = dypos_r ? (y_r >= ey_r) : (y_r <= ey_r);
    brk = (rx && ry) || (x_r < 0 && !dxpos_r) || (x_r >= COLS_S && (dxpos_r || dxz_r)) ||
          (y_r < 0 && !dypos_r) || (y_r >= ROWS_S && (dypos_r || dyz_r));
    in_grid  = x_r >= 0 && x_r < COLS_S && y_r >= 0 && y_r < ROWS_S;
    cell_idx = grwhf_pkg::GRID_IDX_W'(x_r[grwhf_pkg::GRID_POS_BITS-1:0]) +
               grwhf_pkg::GRID_IDX_W'(y_r[grwhf_pkg::GRID_POS_BITS-1:0]) *
               grwhf_pkg::GRID_IDX_W'(GRID_COLUMNS);
    map_rd_addr = cell_idx[grwhf_pkg::MAP_AW-1:0];
  end

  // Crossing fraction from the entry edge product
  logic signed [grwhf_pkg::NUM_W-1:0] num0, num;
  logic signed [PW-1:0] den0, den;
  logic signed [grwhf_pkg::COORD_W-1:0] edge_from;
  logic den_zero, num_le0, num_ge, need_div;

  always_comb begin
    edge_from = stepx_r ? fx_r : fy_r;
    den0      = stepx_r ? dx_r : dy_r;
    num0      = $signed({2'b00, mul_p[grwhf_pkg::EDGE_W-1:0]}) -
                grwhf_pkg::NUM_W'(edge_from);
    num       = den0[PW-1] ? -num0 : num0;
    den       = den0[PW-1] ? -den0 : den0;
    den_zero  = den0 == '0;
    num_le0   = num <= 0;
    num_ge    = num >= grwhf_pkg::NUM_W'(den);
    need_div  = (state_r == S_EDGE) && !den_zero && !num_le0 && !num_ge;
  end

  // Shared unit operand selection
  always_comb begin
    div_req.start    = (state_r == S_DSTART) || need_div;
    if (state_r == S_DSTART) begin
      div_req.dividend = grwhf_pkg::DIVN_W'(fd_mag);
      div_req.divisor  = grwhf_pkg::DIVD_W'(fd_w);
    end else begin
      div_req.dividend = {num[PW-1:0], {grwhf_pkg::FRAC_BITS{1'b0}}};
      div_req.divisor  = den;
    end
    case (state_r)
      S_CHECK: begin
        mul_a = nx_r;
        mul_b = ady_r;
      end
      S_MUL1: begin
        mul_a = ny_r;
        mul_b = adx_r;
      end
      default: begin
        if (stepx_r) begin
          mul_a = grwhf_pkg::NSTEP_W'(dxpos_r ? x_r : x_r + 1'b1);
          mul_b = grwhf_pkg::DIVD_W'(w_eff);
        end else begin
          mul_a = grwhf_pkg::NSTEP_W'(dypos_r ? y_r : y_r + 1'b1);
          mul_b = grwhf_pkg::DIVD_W'(h_eff);
        end
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= grwhf_pkg::CELL_SIZE_RESET;
      cell_height_r <= grwhf_pkg::CELL_SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        grwhf_pkg::CFG_CELL_WIDTH:  cell_width_r  <= cfg_data;
        grwhf_pkg::CFG_CELL_HEIGHT: cell_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A finished result loads the output register once it is free.
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            fx_r       <= in_from_x;
            fy_r       <= in_from_y;
            tx_r       <= in_to_x;
            ty_r       <= in_to_y;
            dx_r       <= in_dx;
            dy_r       <= in_dy;
            adx_r      <= in_dx[PW-1] ? -in_dx : in_dx;
            ady_r      <= in_dy[PW-1] ? -in_dy : in_dy;
            dxpos_r    <= !in_dx[PW-1] && in_dx != '0;
            dypos_r    <= !in_dy[PW-1] && in_dy != '0;
            dxz_r      <= in_dx == '0;
            dyz_r      <= in_dy == '0;
            sel_r      <= 2'd0;
            res_hit_r  <= 1'b0;
            res_col_r  <= '0;
            res_row_r  <= '0;
            if (in_command == grwhf_pkg::CMD_WRITE) begin
              res_frac_r <= '0;
              state_r    <= S_DONE;
            end else begin
              res_frac_r <= grwhf_pkg::FRAC_ONE;
              state_r    <= (in_dx == '0 && in_dy == '0) ? S_DONE : S_DSTART;
            end
          end
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            case (sel_r)
              2'd0: begin
                x_r  <= fd_pos;
                nx_r <= fd_n;
              end
              2'd1: begin
                y_r  <= fd_pos;
                ny_r <= fd_n;
              end
              2'd2:    ex_r <= fd_pos;
              default: ey_r <= fd_pos;
            endcase
            sel_r   <= sel_r + 1'b1;
            state_r <= (sel_r == 2'd3) ? S_CHECK : S_DSTART;
          end
        end
        S_CHECK: begin
          if (brk) begin
            state_r <= S_DONE;
          end else if (dyz_r) begin
            stepx_r <= 1'b1;
            state_r <= S_STEP;
          end else if (dxz_r) begin
            stepx_r <= 1'b0;
            state_r <= S_STEP;
          end else begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod_a_r <= mul_p;
          state_r  <= S_MUL2;
        end
        S_MUL2: begin
          // Ties step in Y.
          stepx_r <= prod_a_r < mul_p;
          state_r <= S_STEP;
        end
        S_STEP: begin
          if (stepx_r) begin
            nx_r <= nx_r + grwhf_pkg::NSTEP_W'(w_eff);
            x_r  <= dxpos_r ? x_r + 1'b1 : x_r - 1'b1;
          end else begin
            ny_r <= ny_r + grwhf_pkg::NSTEP_W'(h_eff);
            y_r  <= dypos_r ? y_r + 1'b1 : y_r - 1'b1;
          end
          state_r <= S_TEST;
        end
        S_TEST: begin
          if (in_grid && cell_idx < grwhf_pkg::GRID_IDX_W'(grwhf_pkg::MAP_DEPTH)) begin
            state_r <= S_READ;
          end else begin
            state_r <= S_CHECK;
          end
        end
        S_READ: state_r <= map_rd_bit ? S_EDGE : S_CHECK;
        S_EDGE: begin
          res_hit_r <= 1'b1;
          res_col_r <= x_r[grwhf_pkg::COL_W-1:0];
          res_row_r <= y_r[grwhf_pkg::ROW_W-1:0];
          if (den_zero || num_ge) begin
            res_frac_r <= grwhf_pkg::FRAC_ONE;
            state_r    <= S_DONE;
          end else if (num_le0) begin
            res_frac_r <= '0;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            res_frac_r <= div_rsp.quotient[grwhf_pkg::FRAC_W-1:0];
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r <= {3'b000, res_row_r, res_col_r, res_frac_r, res_hit_r};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
